>>> rtl/item_stack_with_swap_and_roll_assert.svh
// assertion macros for the stack sequencer
`ifndef ITEM_STACK_WITH_SWAP_AND_ROLL_ASSERT_SVH
`define ITEM_STACK_WITH_SWAP_AND_ROLL_ASSERT_SVH

// same-cycle implication
`define ISWR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack sequencer check failed");

// next-cycle implication
`define ISWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack sequencer check failed");

`endif

>>> rtl/iswr_pkg.sv
`default_nettype none

package iswr_pkg;

   // stack geometry
   localparam int unsigned DEPTH   = 16;
   localparam int unsigned ITEM_W  = 32;
   localparam int unsigned POS_W   = 4;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH       = 3'd0,
      KIND_POP        = 3'd1,
      KIND_SWAP       = 3'd2,
      KIND_ROLL_LEFT  = 3'd3,
      KIND_ROLL_RIGHT = 3'd4,
      KIND_READ_AT    = 3'd5
   } kind_type;

   // memory access from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ITEM_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // finished result offered to the output register
   typedef struct packed {
      logic               valid;
      logic [ITEM_W-1:0]  item;
      logic               item_valid;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } done_type;

endpackage

`default_nettype wire

>>> rtl/iswr_ram.sv
`default_nettype none

module iswr_ram #(
   parameter int unsigned WIDTH  = 32,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/iswr_seq.sv
`default_nettype none
`include "item_stack_with_swap_and_roll_assert.svh"

module iswr_seq (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 cmd_valid,
   output logic                                      cmd_ready,
   input  wire logic [iswr_pkg::KIND_W-1:0]          cmd_kind,
   input  wire logic [iswr_pkg::ITEM_W-1:0]          cmd_value,
   input  wire logic [iswr_pkg::POS_W-1:0]           cmd_pos,
   output iswr_pkg::mem_req_type                     mem_req,
   input  wire logic [iswr_pkg::ITEM_W-1:0]          rd_data,
   output iswr_pkg::done_type                        done,
   input  wire logic                                 out_free
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_SAVE,
      ST_MOVE,
      ST_END,
      ST_FIN
   } state_type;

   state_type                         state_ff, state_in;
   logic [iswr_pkg::COUNT_W-1:0]      count_ff, count_in;
   iswr_pkg::kind_type                kind_ff, kind_in;
   logic [iswr_pkg::ITEM_W-1:0]       value_ff, value_in;
   logic [iswr_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [iswr_pkg::ADDR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [iswr_pkg::ADDR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [iswr_pkg::ADDR_W-1:0]       end_ptr_ff, end_ptr_in;
   logic [iswr_pkg::ITEM_W-1:0]       hold_ff, hold_in;
   logic [iswr_pkg::ITEM_W-1:0]       res_item_ff, res_item_in;
   logic                              res_valid_ff, res_valid_in;
   logic                              res_ovf_ff, res_ovf_in;

   logic [iswr_pkg::COUNT_W-1:0]      pos_ext;
   logic [iswr_pkg::ADDR_W-1:0]       top_addr;
   logic [iswr_pkg::ADDR_W-1:0]       below_top_addr;
   logic [iswr_pkg::ADDR_W-1:0]       other_addr;
   logic                              move_left;
   logic                              move_last;

   // addresses derived from the fill level
   assign pos_ext        = iswr_pkg::COUNT_W'(pos_ff);
   assign top_addr       = iswr_pkg::ADDR_W'(count_ff - iswr_pkg::COUNT_W'(1));
   assign below_top_addr = iswr_pkg::ADDR_W'(count_ff - iswr_pkg::COUNT_W'(2));
   assign other_addr     = iswr_pkg::ADDR_W'(count_ff - iswr_pkg::COUNT_W'(1) - pos_ext);

   // roll left walks downwards, roll right and swap upwards
   assign move_left = (kind_ff == iswr_pkg::KIND_ROLL_LEFT);
   assign move_last = (kind_ff == iswr_pkg::KIND_SWAP)
                   || (move_left && (wr_ptr_ff == iswr_pkg::ADDR_W'(1)))
                   || ((kind_ff == iswr_pkg::KIND_ROLL_RIGHT) && (wr_ptr_ff == below_top_addr));

   // next-state and memory access decode
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      end_ptr_in   = end_ptr_ff;
      hold_in      = hold_ff;
      res_item_in  = res_item_ff;
      res_valid_in = res_valid_ff;
      res_ovf_in   = res_ovf_ff;

      cmd_ready       = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = wr_ptr_ff;
      mem_req.wr_data = rd_data;
      mem_req.rd_addr = rd_ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               kind_in  = iswr_pkg::kind_type'(cmd_kind);
               value_in = cmd_value;
               pos_in   = cmd_pos;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_item_in  = '0;
            res_valid_in = 1'b0;
            res_ovf_in   = 1'b0;
            state_in     = ST_FIN;
            case (kind_ff)
               iswr_pkg::KIND_PUSH: begin
                  if (count_ff < iswr_pkg::COUNT_W'(iswr_pkg::DEPTH)) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = count_ff[iswr_pkg::ADDR_W-1:0];
                     mem_req.wr_data = value_ff;
                     count_in        = count_ff + iswr_pkg::COUNT_W'(1);
                  end else begin
                     res_ovf_in = 1'b1;
                  end
               end
               iswr_pkg::KIND_POP: begin
                  if (count_ff != '0) begin
                     count_in        = count_ff - iswr_pkg::COUNT_W'(1);
                     mem_req.rd_addr = top_addr;
                     state_in        = ST_LOAD;
                  end
               end
               iswr_pkg::KIND_READ_AT: begin
                  if (pos_ext < count_ff) begin
                     mem_req.rd_addr = other_addr;
                     state_in        = ST_LOAD;
                  end
               end
               iswr_pkg::KIND_SWAP: begin
                  if ((pos_ff != '0) && (pos_ext < count_ff)) begin
                     mem_req.rd_addr = top_addr;
                     rd_ptr_in       = other_addr;
                     wr_ptr_in       = top_addr;
                     end_ptr_in      = other_addr;
                     state_in        = ST_SAVE;
                  end
               end
               iswr_pkg::KIND_ROLL_LEFT: begin
                  if (count_ff > iswr_pkg::COUNT_W'(1)) begin
                     mem_req.rd_addr = top_addr;
                     rd_ptr_in       = top_addr - iswr_pkg::ADDR_W'(1);
                     wr_ptr_in       = top_addr;
                     end_ptr_in      = '0;
                     state_in        = ST_SAVE;
                  end
               end
               iswr_pkg::KIND_ROLL_RIGHT: begin
                  if (count_ff > iswr_pkg::COUNT_W'(1)) begin
                     mem_req.rd_addr = '0;
                     rd_ptr_in       = iswr_pkg::ADDR_W'(1);
                     wr_ptr_in       = '0;
                     end_ptr_in      = top_addr;
                     state_in        = ST_SAVE;
                  end
               end
               default: begin
               end
            endcase
         end

         // read data of pop or read at arrives
         ST_LOAD: begin
            res_item_in  = rd_data;
            res_valid_in = 1'b1;
            state_in     = ST_FIN;
         end

         // keep the item that is displaced, start reading ahead
         ST_SAVE: begin
            hold_in         = rd_data;
            mem_req.rd_addr = rd_ptr_ff;
            rd_ptr_in       = move_left ? rd_ptr_ff - iswr_pkg::ADDR_W'(1)
                                        : rd_ptr_ff + iswr_pkg::ADDR_W'(1);
            state_in        = ST_MOVE;
         end

         // write back the entry read last cycle, read the next one
         ST_MOVE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wr_ptr_ff;
            mem_req.wr_data = rd_data;
            mem_req.rd_addr = rd_ptr_ff;
            rd_ptr_in       = move_left ? rd_ptr_ff - iswr_pkg::ADDR_W'(1)
                                        : rd_ptr_ff + iswr_pkg::ADDR_W'(1);
            wr_ptr_in       = move_left ? wr_ptr_ff - iswr_pkg::ADDR_W'(1)
                                        : wr_ptr_ff + iswr_pkg::ADDR_W'(1);
            if (move_last) begin
               state_in = ST_END;
            end
         end

         // the saved item lands at the far end
         ST_END: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = end_ptr_ff;
            mem_req.wr_data = hold_ff;
            state_in        = ST_FIN;
         end

         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result offered to the output register
   always_comb begin
      done.valid      = (state_ff == ST_FIN);
      done.item       = res_item_ff;
      done.item_valid = res_valid_ff;
      done.count      = count_ff;
      done.overflow   = res_ovf_ff;
   end

   // state and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      pos_ff       <= pos_in;
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      end_ptr_ff   <= end_ptr_in;
      hold_ff      <= hold_in;
      res_item_ff  <= res_item_in;
      res_valid_ff <= res_valid_in;
      res_ovf_ff   <= res_ovf_in;
   end

   // fill level never passes the memory depth
   `ISWR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= iswr_pkg::COUNT_W'(iswr_pkg::DEPTH))
   // the memory is left alone between transactions
   `ISWR_ASSERT_SAME(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !mem_req.wr_en)
   // only the dispatch step alters the fill level
   `ISWR_ASSERT_NEXT(a_count_hold, clock, reset, state_ff != ST_EXEC, $stable(count_ff))

endmodule

`default_nettype wire

>>> rtl/item_stack_with_swap_and_roll.sv
// channel   | direction | handshake         | payload
// req_      | in        | req_valid/ready   | kind, push_value, position
// rsp_      | out       | rsp_valid/ready   | item_out, item_valid, count_now, overflow
//
// push, unused codes and any operation that changes nothing go from dispatch to
// the final step; pop and read at returning an item pass a load step. swap and
// rolls pass save, move (repeated in rolls) and end, moving each item once.
// reset is synchronous and empties the stack; stored words are not cleared.
// a new request is taken only once the previous result sits in the output
// register; a stalled output holds the sequencer in its final step.
`default_nettype none

module item_stack_with_swap_and_roll (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [iswr_pkg::KIND_W-1:0]         req_kind,
   input  wire logic [iswr_pkg::ITEM_W-1:0]         req_push_value,
   input  wire logic [iswr_pkg::POS_W-1:0]          req_position,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [iswr_pkg::ITEM_W-1:0]         rsp_item_out,
   output logic                                     rsp_item_valid,
   output logic      [iswr_pkg::COUNT_W-1:0]        rsp_count_now,
   output logic                                     rsp_overflow
);

   iswr_pkg::mem_req_type            mem_req;
   iswr_pkg::done_type               done;
   logic [iswr_pkg::ITEM_W-1:0]      rd_data;
   logic                             out_free;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [iswr_pkg::ITEM_W-1:0]      rsp_item_ff, rsp_item_in;
   logic                             rsp_item_valid_ff, rsp_item_valid_in;
   logic [iswr_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                             rsp_overflow_ff, rsp_overflow_in;

   // item store
   iswr_ram #(
      .WIDTH (iswr_pkg::ITEM_W),
      .DEPTH (iswr_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // operation sequencer
   iswr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_valid),
      .cmd_ready (req_ready),
      .cmd_kind  (req_kind),
      .cmd_value (req_push_value),
      .cmd_pos   (req_position),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .done      (done),
      .out_free  (out_free)
   );

   // output register loads when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_item_in       = rsp_item_ff;
      rsp_item_valid_in = rsp_item_valid_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_overflow_in   = rsp_overflow_ff;
      if (out_free) begin
         rsp_valid_in = done.valid;
         if (done.valid) begin
            rsp_item_in       = done.item;
            rsp_item_valid_in = done.item_valid;
            rsp_count_in      = done.count;
            rsp_overflow_in   = done.overflow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff       <= rsp_item_in;
      rsp_item_valid_ff <= rsp_item_valid_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_out   = rsp_item_ff;
   assign rsp_item_valid = rsp_item_valid_ff;
   assign rsp_count_now  = rsp_count_ff;
   assign rsp_overflow   = rsp_overflow_ff;

endmodule

`default_nettype wire
